>>> rtl/core/tkl_pkg.sv
// Package with the shared types and constants of the top-k smallest distance list.
`timescale 1ns / 1ps

package tkl_pkg;

  localparam int KEY_W        = 16;
  localparam int ID_W         = 16;
  localparam int OP_W         = 2;
  localparam int RANK_W       = 4;
  localparam int CAP_W        = 5;
  localparam int RESULT_LIMIT = 16;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DUMP   = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_INS,
    ST_DUMP
  } ctl_state_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [ID_W-1:0]  first_id;
    logic [ID_W-1:0]  second_id;
  } entry_t;

  typedef struct packed {
    logic latch;
    logic clear;
    logic emit_zero;
    logic compare;
    logic insert;
    logic dump_step;
  } ctl_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic dump_last;
  } ctl_sts_t;

endpackage

>>> rtl/core/tkl_ctrl.sv
// Controller state machine that sequences insert, dump and clear requests.
`timescale 1ns / 1ps

module tkl_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [tkl_pkg::OP_W-1:0] in_operation,
  input  tkl_pkg::ctl_sts_t      sts,
  output tkl_pkg::ctl_cmd_t      cmd,
  output logic                   busy
);
  import tkl_pkg::*;

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = (state_r != ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          unique case (in_operation)
            OP_INSERT: state_nxt = ST_CMP;
            OP_DUMP: begin
              if (sts.count_zero) begin
                cmd.emit_zero = 1'b1;
              end else begin
                state_nxt = ST_DUMP;
              end
            end
            OP_CLEAR: begin
              cmd.clear     = 1'b1;
              cmd.emit_zero = 1'b1;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_CMP: begin
        cmd.compare = 1'b1;
        state_nxt   = ST_INS;
      end
      ST_INS: begin
        cmd.insert = 1'b1;
        state_nxt  = ST_IDLE;
      end
      ST_DUMP: begin
        cmd.dump_step = 1'b1;
        if (sts.dump_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

>>> rtl/core/tkl_datapath.sv
// Datapath with the sorted entry cells, compare vector, count and result registers.
`timescale 1ns / 1ps

module tkl_datapath #(
  parameter int LIST_DEPTH = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  tkl_pkg::ctl_cmd_t         cmd,
  output tkl_pkg::ctl_sts_t         sts,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [tkl_pkg::CAP_W-1:0] cfg_data,
  input  logic [tkl_pkg::KEY_W-1:0] in_distance_key,
  input  logic [tkl_pkg::ID_W-1:0]  in_first_id,
  input  logic [tkl_pkg::ID_W-1:0]  in_second_id,
  output logic                      out_strobe,
  output logic                      out_entry_valid,
  output logic                      out_stored,
  output logic [tkl_pkg::RANK_W-1:0] out_rank,
  output logic [tkl_pkg::KEY_W-1:0] out_distance,
  output logic [tkl_pkg::ID_W-1:0]  out_first_id,
  output logic [tkl_pkg::ID_W-1:0]  out_second_id,
  output logic                      out_last
);
  import tkl_pkg::*;

  localparam int CW    = $clog2(LIST_DEPTH + 1);
  localparam int IW    = $clog2(LIST_DEPTH);
  localparam int LIMIT = (LIST_DEPTH < RESULT_LIMIT) ? LIST_DEPTH : RESULT_LIMIT;
  localparam logic [CAP_W-1:0] LIMIT_C = CAP_W'(LIMIT);

  logic [CAP_W-1:0]      cap_r;
  logic [CAP_W-1:0]      cap_sat;
  logic [CW-1:0]         cap_eff;
  logic [CW-1:0]         cap_m1;
  logic [CW-1:0]         count_r;
  logic [CW-1:0]         count_m1;
  logic [IW-1:0]         dump_idx_r;
  entry_t                new_r;
  entry_t                ent_r [LIST_DEPTH];
  logic [LIST_DEPTH-1:0] le_r;
  logic [LIST_DEPTH-1:0] edge_v;
  logic [IW-1:0]         pos;
  logic                  full;

  logic                  strobe_r;
  logic                  valid_r;
  logic                  stored_r;
  logic [RANK_W-1:0]     rank_r;
  entry_t                res_r;
  logic                  last_r;

  assign cfg_ready = 1'b1;

  always_comb begin
    if (cap_r == '0) begin
      cap_sat = CAP_W'(1);
    end else if (cap_r > LIMIT_C) begin
      cap_sat = LIMIT_C;
    end else begin
      cap_sat = cap_r;
    end
  end

  assign cap_eff  = CW'(cap_sat);
  assign cap_m1   = cap_eff - CW'(1);
  assign count_m1 = count_r - CW'(1);
  assign full     = (count_r == cap_eff) && le_r[cap_m1[IW-1:0]];

  assign sts.count_zero = (count_r == '0);
  assign sts.dump_last  = (CW'(dump_idx_r) == count_m1);

  always_comb begin
    for (int i = 0; i < LIST_DEPTH; i++) begin
      if (i == 0) begin
        edge_v[i] = !le_r[i];
      end else begin
        edge_v[i] = !le_r[i] && le_r[i-1];
      end
    end
  end

  always_comb begin
    for (int b = 0; b < IW; b++) begin
      pos[b] = 1'b0;
      for (int i = 0; i < LIST_DEPTH; i++) begin
        if (((i >> b) & 1) == 1) begin
          pos[b] = pos[b] | edge_v[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r      <= CAP_RESET;
      count_r    <= '0;
      dump_idx_r <= '0;
      strobe_r   <= 1'b0;
    end else begin
      strobe_r <= cmd.emit_zero || cmd.insert || cmd.dump_step;
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_data;
      end
      if (cmd.clear) begin
        count_r <= '0;
      end else if (cmd.latch) begin
        count_r <= (count_r > cap_eff) ? cap_eff : count_r;
      end else if (cmd.insert && !full && (count_r < cap_eff)) begin
        count_r <= count_r + CW'(1);
      end
      if (cmd.latch) begin
        dump_idx_r <= '0;
      end else if (cmd.dump_step) begin
        dump_idx_r <= dump_idx_r + IW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      new_r.key       <= in_distance_key;
      new_r.first_id  <= in_first_id;
      new_r.second_id <= in_second_id;
    end
    if (cmd.compare) begin
      for (int i = 0; i < LIST_DEPTH; i++) begin
        le_r[i] <= (CW'(i) < count_r) && (ent_r[i].key <= new_r.key);
      end
    end
    if (cmd.insert && !full) begin
      for (int i = 0; i < LIST_DEPTH; i++) begin
        if (!le_r[i]) begin
          if (i == 0) begin
            ent_r[i] <= new_r;
          end else if (le_r[i-1]) begin
            ent_r[i] <= new_r;
          end else begin
            ent_r[i] <= ent_r[i-1];
          end
        end
      end
    end
    if (cmd.dump_step) begin
      for (int i = 0; i < LIST_DEPTH; i++) begin
        if (CW'(i) == count_m1) begin
          ent_r[i] <= ent_r[0];
        end else if (i < LIST_DEPTH - 1) begin
          ent_r[i] <= ent_r[(i + 1) % LIST_DEPTH];
        end
      end
    end
    priority if (cmd.insert) begin
      valid_r  <= !full;
      stored_r <= !full;
      rank_r   <= full ? '0 : RANK_W'(pos);
      res_r    <= full ? '0 : new_r;
      last_r   <= 1'b1;
    end else if (cmd.dump_step) begin
      valid_r  <= 1'b1;
      stored_r <= 1'b0;
      rank_r   <= RANK_W'(dump_idx_r);
      res_r    <= ent_r[0];
      last_r   <= sts.dump_last;
    end else if (cmd.emit_zero) begin
      valid_r  <= 1'b0;
      stored_r <= 1'b0;
      rank_r   <= '0;
      res_r    <= '0;
      last_r   <= 1'b1;
    end
  end

  assign out_strobe      = strobe_r;
  assign out_entry_valid = valid_r;
  assign out_stored      = stored_r;
  assign out_rank        = rank_r;
  assign out_distance    = res_r.key;
  assign out_first_id    = res_r.first_id;
  assign out_second_id   = res_r.second_id;
  assign out_last        = last_r;

  a_insert_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.insert && !full |-> $onehot(edge_v))
    else $error("insert position is not unique");

  a_dump_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.dump_step |-> count_r != '0)
    else $error("dump step on an empty list");

  a_insert_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.insert |=> out_strobe && out_last)
    else $error("insert did not give a final result");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.insert |-> count_r <= cap_eff)
    else $error("entry count above capacity during insert");

endmodule

>>> rtl/core/top_k_smallest_distance_list_top.sv
// Top level of the top-k smallest distance list: controller and datapath.
`timescale 1ns / 1ps

// Channel   Handshake                  Payload
// in_       start / busy               in_operation, in_distance_key, in_first_id,
//                                      in_second_id
// out_      out_strobe (one cycle)     out_entry_valid, out_stored, out_rank,
//                                      out_distance, out_first_id, out_second_id, out_last
// cfg_      cfg_valid / cfg_ready      cfg_data (capacity)
//
// An insert is accepted, then compared against all cells, then shifted and reported.
// A dump reports the stored entries one by one after acceptance; the cells rotate through
// position zero. A clear or a dump of an empty list is done in the accept cycle.
// Each result appears in the cycle after the step that makes it. Reset empties the list
// and sets the capacity to 16. The receiver cannot stall results.
module top_k_smallest_distance_list_top #(
  parameter int LIST_DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [tkl_pkg::OP_W-1:0]   in_operation,
  input  logic [tkl_pkg::KEY_W-1:0]  in_distance_key,
  input  logic [tkl_pkg::ID_W-1:0]   in_first_id,
  input  logic [tkl_pkg::ID_W-1:0]   in_second_id,
  output logic                       out_strobe,
  output logic                       out_entry_valid,
  output logic                       out_stored,
  output logic [tkl_pkg::RANK_W-1:0] out_rank,
  output logic [tkl_pkg::KEY_W-1:0]  out_distance,
  output logic [tkl_pkg::ID_W-1:0]   out_first_id,
  output logic [tkl_pkg::ID_W-1:0]   out_second_id,
  output logic                       out_last,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [tkl_pkg::CAP_W-1:0]  cfg_data
);
  import tkl_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  tkl_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_operation (in_operation),
    .sts          (sts),
    .cmd          (cmd),
    .busy         (busy)
  );

  tkl_datapath #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .in_distance_key (in_distance_key),
    .in_first_id     (in_first_id),
    .in_second_id    (in_second_id),
    .out_strobe      (out_strobe),
    .out_entry_valid (out_entry_valid),
    .out_stored      (out_stored),
    .out_rank        (out_rank),
    .out_distance    (out_distance),
    .out_first_id    (out_first_id),
    .out_second_id   (out_second_id),
    .out_last        (out_last)
  );

endmodule

>>> verif/tkl_list_checker.sv
// Checker for the top-k smallest distance list: predicts responses and compares them.
`timescale 1ns / 1ps

module tkl_list_checker #(
  parameter int LIST_DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       busy,
  input  logic [tkl_pkg::OP_W-1:0]   in_operation,
  input  logic [tkl_pkg::KEY_W-1:0]  in_distance_key,
  input  logic [tkl_pkg::ID_W-1:0]   in_first_id,
  input  logic [tkl_pkg::ID_W-1:0]   in_second_id,
  input  logic                       out_strobe,
  input  logic                       out_entry_valid,
  input  logic                       out_stored,
  input  logic [tkl_pkg::RANK_W-1:0] out_rank,
  input  logic [tkl_pkg::KEY_W-1:0]  out_distance,
  input  logic [tkl_pkg::ID_W-1:0]   out_first_id,
  input  logic [tkl_pkg::ID_W-1:0]   out_second_id,
  input  logic                       out_last,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [tkl_pkg::CAP_W-1:0]  cfg_data,
  output int                         mismatch_count,
  output int                         pending_count
);
  import tkl_pkg::*;

  typedef struct packed {
    logic              entry_valid;
    logic              stored;
    logic [RANK_W-1:0] rank;
    logic [KEY_W-1:0]  distance;
    logic [ID_W-1:0]   first_id;
    logic [ID_W-1:0]   second_id;
    logic              last;
  } list_report_t;

  entry_t           kept_entries[LIST_DEPTH];
  int               kept_count = 0;
  logic [CAP_W-1:0] capacity_reg = CAP_RESET;
  list_report_t     due_reports[$];

  function automatic int kept_limit();
    int lim;
    lim = int'(capacity_reg);
    if (lim < 1) lim = 1;
    if (lim > LIST_DEPTH) lim = LIST_DEPTH;
    if (lim > RESULT_LIMIT) lim = RESULT_LIMIT;
    return lim;
  endfunction

  task automatic push_report(input logic valid, input logic stored, input int rank,
                             input entry_t e, input logic last);
    list_report_t r;
    r.entry_valid = valid;
    r.stored      = stored;
    r.rank        = rank[RANK_W-1:0];
    r.distance    = e.key;
    r.first_id    = e.first_id;
    r.second_id   = e.second_id;
    r.last        = last;
    due_reports.push_back(r);
  endtask

  task automatic predict_list_response(input logic [OP_W-1:0] op, input entry_t req);
    int lim;
    int pos;
    int top;
    entry_t blank;
    blank = '0;
    lim = kept_limit();
    if (kept_count > lim) kept_count = lim;
    case (op)
      OP_INSERT: begin
        if (kept_count >= lim && req.key >= kept_entries[lim-1].key) begin
          push_report(1'b0, 1'b0, 0, blank, 1'b1);
        end else begin
          pos = 0;
          while (pos < kept_count && kept_entries[pos].key <= req.key) pos++;
          top = (kept_count < lim) ? kept_count : lim - 1;
          for (int i = top; i > pos; i--) kept_entries[i] = kept_entries[i-1];
          kept_entries[pos] = req;
          if (kept_count < lim) kept_count++;
          push_report(1'b1, 1'b1, pos, req, 1'b1);
        end
      end
      OP_DUMP: begin
        if (kept_count == 0) begin
          push_report(1'b0, 1'b0, 0, blank, 1'b1);
        end else begin
          for (int i = 0; i < kept_count; i++)
            push_report(1'b1, 1'b0, i, kept_entries[i], i + 1 == kept_count);
        end
      end
      OP_CLEAR: begin
        kept_count = 0;
        push_report(1'b0, 1'b0, 0, blank, 1'b1);
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk) begin
    list_report_t got;
    list_report_t want;
    entry_t req;
    if (!rst_n) begin
      kept_count   = 0;
      capacity_reg = CAP_RESET;
      due_reports.delete();
    end else begin
      if (out_strobe) begin
        got = '{out_entry_valid, out_stored, out_rank, out_distance, out_first_id,
                out_second_id, out_last};
        if (due_reports.size() == 0) begin
          if (mismatch_count < 10)
            $display("checker: response with none outstanding: ",
                     "v=%0b st=%0b rank=%0d dist=%h a=%h b=%h last=%0b",
                     got.entry_valid, got.stored, got.rank, got.distance, got.first_id,
                     got.second_id, got.last);
          mismatch_count++;
        end else begin
          want = due_reports.pop_front();
          if (got.entry_valid !== want.entry_valid || got.stored !== want.stored ||
              got.rank !== want.rank || got.distance !== want.distance ||
              got.first_id !== want.first_id || got.second_id !== want.second_id ||
              got.last !== want.last) begin
            if (mismatch_count < 10)
              $display("checker: response mismatch at %0t: ", $realtime,
                       "expected v=%0b st=%0b rank=%0d dist=%h a=%h b=%h last=%0b, ",
                       want.entry_valid, want.stored, want.rank, want.distance,
                       want.first_id, want.second_id, want.last,
                       "got v=%0b st=%0b rank=%0d dist=%h a=%h b=%h last=%0b",
                       got.entry_valid, got.stored, got.rank, got.distance,
                       got.first_id, got.second_id, got.last);
            mismatch_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) capacity_reg = cfg_data;
      if (start && !busy) begin
        req.key       = in_distance_key;
        req.first_id  = in_first_id;
        req.second_id = in_second_id;
        predict_list_response(in_operation, req);
      end
    end
    pending_count = due_reports.size();
  end

endmodule

>>> verif/tb.sv
// Testbench top for the top-k smallest distance list: stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module tb;
  import tkl_pkg::*;

  localparam int IDLE_LIMIT = 2000;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [OP_W-1:0]   in_operation = OP_INSERT;
  logic [KEY_W-1:0]  in_distance_key = '0;
  logic [ID_W-1:0]   in_first_id = '0;
  logic [ID_W-1:0]   in_second_id = '0;
  logic              out_strobe;
  logic              out_entry_valid;
  logic              out_stored;
  logic [RANK_W-1:0] out_rank;
  logic [KEY_W-1:0]  out_distance;
  logic [ID_W-1:0]   out_first_id;
  logic [ID_W-1:0]   out_second_id;
  logic              out_last;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CAP_W-1:0]  cfg_data = '0;
  int                mismatch_count;
  int                pending_count;
  int                burst_left = 0;
  int                quiet_cycles = 0;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  always #2 clk = ~clk;

  top_k_smallest_distance_list_top #(.LIST_DEPTH(16)) u_dut (
    .clk, .rst_n, .start, .busy, .in_operation, .in_distance_key, .in_first_id,
    .in_second_id, .out_strobe, .out_entry_valid, .out_stored, .out_rank, .out_distance,
    .out_first_id, .out_second_id, .out_last, .cfg_valid, .cfg_ready, .cfg_data
  );

  tkl_list_checker #(.LIST_DEPTH(16)) u_checker (
    .clk, .rst_n, .start, .busy, .in_operation, .in_distance_key, .in_first_id,
    .in_second_id, .out_strobe, .out_entry_valid, .out_stored, .out_rank, .out_distance,
    .out_first_id, .out_second_id, .out_last, .cfg_valid, .cfg_ready, .cfg_data,
    .mismatch_count, .pending_count
  );

  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_strobe || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= IDLE_LIMIT) begin
        $display("tb: errors");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic issue_request(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                               input logic [ID_W-1:0] fid, input logic [ID_W-1:0] sid);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 4) == 0) ? 24 : $urandom_range(1, 6);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    start           <= 1'b1;
    in_operation    <= op;
    in_distance_key <= key;
    in_first_id     <= fid;
    in_second_id    <= sid;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic settle();
    start <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_phase(input logic [CAP_W-1:0] cap, input int count);
    int pick;
    logic [OP_W-1:0] op;
    logic [KEY_W-1:0] key;
    write_capacity(cap);
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 78) op = OP_INSERT;
      else if (pick < 91) op = OP_DUMP;
      else if (pick < 96) op = OP_CLEAR;
      else op = OP_UNUSED;
      case ($urandom_range(0, 3))
        0: key = KEY_W'($urandom_range(0, 7));
        1: key = $urandom_range(0, 1) ? '1 : '0;
        default: key = KEY_W'($urandom);
      endcase
      issue_request(op, key, ID_W'($urandom), ID_W'($urandom));
    end
    settle();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);

    issue_request(OP_DUMP, 16'h1234, 16'h0001, 16'h0002);
    issue_request(OP_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    issue_request(OP_INSERT, 16'h8000, 16'h0001, 16'h0002);
    issue_request(OP_INSERT, 16'h0000, 16'hFFFF, 16'h0000);
    issue_request(OP_INSERT, 16'hFFFF, 16'h0000, 16'hFFFF);
    issue_request(OP_INSERT, 16'h8000, 16'hAAAA, 16'h5555);
    issue_request(OP_UNUSED, 16'h4444, 16'h1111, 16'h2222);
    issue_request(OP_DUMP, 16'h0000, 16'h0000, 16'h0000);
    issue_request(OP_CLEAR, 16'h0000, 16'h0000, 16'h0000);
    issue_request(OP_DUMP, 16'h0000, 16'h0000, 16'h0000);
    settle();

    write_capacity(5'd1);
    issue_request(OP_INSERT, 16'h0005, 16'h0101, 16'h0202);
    issue_request(OP_INSERT, 16'h0005, 16'h0303, 16'h0404);
    issue_request(OP_INSERT, 16'h0003, 16'h0505, 16'h0606);
    issue_request(OP_INSERT, 16'hFFFF, 16'h0707, 16'h0808);
    issue_request(OP_DUMP, 16'h0000, 16'h0000, 16'h0000);
    settle();

    write_capacity(5'd0);
    issue_request(OP_INSERT, 16'h0000, 16'h1357, 16'h2468);
    issue_request(OP_INSERT, 16'h0000, 16'h9ABC, 16'hDEF0);
    issue_request(OP_DUMP, 16'h0000, 16'h0000, 16'h0000);
    settle();

    random_phase(5'd16, 30);
    random_phase(5'd31, 20);
    random_phase(5'd3, 15);
    random_phase(5'd1, 10);
    random_phase(CAP_W'($urandom_range(2, 15)), 25);

    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
